/* sv/zip_local_header_manifest_scanner_defines.svh */
// Assertion macros for the ZIP local header manifest scanner.
// Included by the top level; no other dependencies.
`ifndef ZIP_LOCAL_HEADER_MANIFEST_SCANNER_DEFINES_SVH
`define ZIP_LOCAL_HEADER_MANIFEST_SCANNER_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted.
`define ZLHM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ZLHM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ZLHM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ZLHM_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* sv/zlhm_pkg.sv */
// Shared types, constants and the manifest path table for the scanner.
// No dependencies.
`default_nettype none

package zlhm_pkg;

    localparam logic [31:0] LOCAL_MAGIC  = 32'h04034b50;
    localparam logic [4:0]  HDR_LAST     = 5'd29;   // index of the 30th header byte
    localparam logic [4:0]  MAGIC_END    = 5'd4;
    localparam logic [4:0]  PSIZE_FIRST  = 5'd18;
    localparam logic [4:0]  PSIZE_END    = 5'd22;
    localparam logic [4:0]  NLEN_FIRST   = 5'd26;
    localparam logic [4:0]  XLEN_FIRST   = 5'd28;
    localparam logic [15:0] PATH_LEN     = 16'd20;
    localparam logic [4:0]  PATH_LAST    = 5'd19;
    localparam logic [15:0] ENTRY_MAX    = 16'hFFFF;

    typedef enum logic [1:0] {
        VERDICT_NONE  = 2'd0,
        VERDICT_FOUND = 2'd1,
        VERDICT_BAD   = 2'd2
    } t_verdict;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_NAME   = 2'd1,
        PH_SKIP   = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    typedef struct packed {
        logic          emit;
        t_verdict      verdict;
        logic [15:0]   entries;
    } t_walk_res;

    // "META-INF/MANIFEST.MF"
    function automatic logic [7:0] manifest_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:    c = 8'h4D; // M
            5'd1:    c = 8'h45; // E
            5'd2:    c = 8'h54; // T
            5'd3:    c = 8'h41; // A
            5'd4:    c = 8'h2D; // -
            5'd5:    c = 8'h49; // I
            5'd6:    c = 8'h4E; // N
            5'd7:    c = 8'h46; // F
            5'd8:    c = 8'h2F; // /
            5'd9:    c = 8'h4D; // M
            5'd10:   c = 8'h41; // A
            5'd11:   c = 8'h4E; // N
            5'd12:   c = 8'h49; // I
            5'd13:   c = 8'h46; // F
            5'd14:   c = 8'h45; // E
            5'd15:   c = 8'h53; // S
            5'd16:   c = 8'h54; // T
            5'd17:   c = 8'h2E; // .
            5'd18:   c = 8'h4D; // M
            5'd19:   c = 8'h46; // F
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/zlhm_walk.sv */
// Header walker: walk state registers and the per-byte next-state logic.
// Depends on zlhm_pkg.
`default_nettype none

module zlhm_walk
    import zlhm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic [7:0]  i_byte,
    input  wire logic        i_last,
    output t_walk_res        o_res
);

    t_phase       r_phase,  n_phase;
    logic [4:0]   r_hcount, n_hcount;
    logic [4:0]   r_idx,    n_idx;
    logic         r_mis,    n_mis;
    logic [33:0]  r_skip,   n_skip;
    logic [15:0]  r_entry,  n_entry;
    logic [31:0]  r_magic,  n_magic;
    logic [31:0]  r_packed, n_packed;
    logic [15:0]  r_name,   n_name;
    logic [15:0]  r_extra,  n_extra;

    logic         skip_start;
    logic [33:0]  skip_amt;
    logic [4:0]   psize_off;
    t_walk_res    res;

    always_comb begin
        n_phase    = r_phase;
        n_hcount   = r_hcount;
        n_idx      = r_idx;
        n_mis      = r_mis;
        n_skip     = r_skip;
        n_entry    = r_entry;
        n_magic    = r_magic;
        n_packed   = r_packed;
        n_name     = r_name;
        n_extra    = r_extra;
        skip_start = 1'b0;
        skip_amt   = '0;
        psize_off  = r_hcount - PSIZE_FIRST;
        res.emit    = 1'b0;
        res.verdict = VERDICT_NONE;
        res.entries = '0;

        case (r_phase)
            PH_HEADER: begin
                // every lane gets rewritten before it is used, so no clear at byte 0
                if (r_hcount < MAGIC_END) begin
                    n_magic[8*r_hcount[1:0] +: 8] = i_byte;
                end else if (r_hcount >= PSIZE_FIRST && r_hcount < PSIZE_END) begin
                    n_packed[8*psize_off[1:0] +: 8] = i_byte;
                end else if (r_hcount[4:1] == NLEN_FIRST[4:1]) begin
                    n_name[8*r_hcount[0] +: 8] = i_byte;
                end else if (r_hcount[4:1] == XLEN_FIRST[4:1]) begin
                    n_extra[8*r_hcount[0] +: 8] = i_byte;
                end
                if (r_hcount == HDR_LAST) begin
                    n_hcount = '0;
                    if (r_magic != LOCAL_MAGIC) begin
                        res.emit    = 1'b1;
                        res.verdict = VERDICT_BAD;
                        n_phase     = PH_DONE;
                    end else begin
                        if (r_entry != ENTRY_MAX) begin
                            n_entry = r_entry + 16'd1;
                        end
                        if (r_name == PATH_LEN) begin
                            n_idx   = '0;
                            n_mis   = 1'b0;
                            n_phase = PH_NAME;
                        end else begin
                            skip_start = 1'b1;
                            skip_amt   = {18'd0, r_name} + {18'd0, n_extra}
                                       + {2'd0, r_packed};
                        end
                    end
                end else begin
                    n_hcount = r_hcount + 5'd1;
                end
            end
            PH_NAME: begin
                n_mis = r_mis | (i_byte != manifest_char(r_idx));
                if (r_idx == PATH_LAST) begin
                    n_idx = '0;
                    if (!n_mis) begin
                        res.emit    = 1'b1;
                        res.verdict = VERDICT_FOUND;
                        n_phase     = PH_DONE;
                    end else begin
                        skip_start = 1'b1;
                        skip_amt   = {18'd0, r_extra} + {2'd0, r_packed};
                    end
                end else begin
                    n_idx = r_idx + 5'd1;
                end
            end
            PH_SKIP: begin
                // skip count is never zero while in this phase
                n_skip = r_skip - 34'd1;
                if (r_skip == 34'd1) begin
                    n_phase = PH_HEADER;
                end
            end
            default: begin
            end
        endcase

        if (skip_start) begin
            n_skip  = skip_amt;
            n_phase = (skip_amt != '0) ? PH_SKIP : PH_HEADER;
        end

        res.entries = n_entry;

        if (i_last) begin
            if (!res.emit && n_phase != PH_DONE) begin
                res.emit    = 1'b1;
                res.verdict = VERDICT_NONE;
            end
            // end of archive re-arms the walker
            n_phase  = PH_HEADER;
            n_hcount = '0;
            n_idx    = '0;
            n_mis    = 1'b0;
            n_skip   = '0;
            n_entry  = '0;
        end
    end

    assign o_res = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_hcount <= '0;
            r_idx    <= '0;
            r_mis    <= 1'b0;
            r_skip   <= '0;
            r_entry  <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_hcount <= n_hcount;
            r_idx    <= n_idx;
            r_mis    <= n_mis;
            r_skip   <= n_skip;
            r_entry  <= n_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_magic  <= n_magic;
            r_packed <= n_packed;
            r_name   <= n_name;
            r_extra  <= n_extra;
        end
    end

endmodule

`default_nettype wire

/* sv/zip_local_header_manifest_scanner.sv */
// Top level: input register, header walker, result register.
// Depends on zlhm_pkg, zlhm_walk and the scanner defines header.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | in        | i_valid / o_ready    | i_data_byte[7:0], i_last
//  out     | out       | o_valid / i_ready    | o_verdict[1:0], o_entries_scanned[15:0]
//
// One archive byte per cycle, except while a verdict byte waits on a stalled result register;
// a byte is held in the input register and its verdict is registered in the result register.
// The input register feeds the walker; the result register holds one verdict beat.
// A byte that makes no verdict moves on even while the result register is stalled.
// Reset is synchronous, active low, and returns the walker to header collection.
`default_nettype none

`include "zip_local_header_manifest_scanner_defines.svh"

module zip_local_header_manifest_scanner
    import zlhm_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    output logic              o_ready,
    input  wire logic [7:0]   i_data_byte,
    input  wire logic         i_last,
    output logic              o_valid,
    input  wire logic         i_ready,
    output logic [1:0]        o_verdict,
    output logic [15:0]       o_entries_scanned
);

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_last;
    logic         r_out_valid;
    t_verdict     r_out_verdict;
    logic [15:0]  r_out_entries;

    t_walk_res    w_res;
    logic         w_out_free;
    logic         w_fire;

    assign w_out_free = !r_out_valid || i_ready;
    assign w_fire     = r_in_valid && (w_out_free || !w_res.emit);
    assign o_ready    = !r_in_valid || w_fire;

    zlhm_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_fire),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_res.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res.emit) begin
            r_out_verdict <= w_res.verdict;
            r_out_entries <= w_res.entries;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_verdict         = r_out_verdict;
    assign o_entries_scanned = r_out_entries;

    // a found manifest always follows at least one counted header
    `ZLHM_ASSERT_IMP(a_found_has_entry, i_clk, i_rst_n,
        r_out_valid && r_out_verdict == VERDICT_FOUND, r_out_entries != 16'd0)
    // a verdict beat is never overwritten while it waits
    `ZLHM_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n,
        r_out_valid && !i_ready && w_res.emit, !w_fire)
    // a drained beat with nothing new behind it leaves the result register empty
    `ZLHM_ASSERT_NXT(a_drain_clears, i_clk, i_rst_n,
        r_out_valid && i_ready && !(w_fire && w_res.emit), !r_out_valid)
    // backpressure on the input only comes from a held byte
    `ZLHM_ASSERT_IMP(a_ready_low_held, i_clk, i_rst_n, !o_ready, r_in_valid)

endmodule

`default_nettype wire

/* test/tb.sv */
// Testbench for zip_local_header_manifest_scanner: byte-stream archives in, verdict beats out.
// Depends on zlhm_pkg and the scanner RTL; expected beats come from an in-bench header walker.
`timescale 1ns / 1ps

module tb;
    import zlhm_pkg::*;

    localparam int          CLK_HALF   = 6;
    localparam int          RST_CYCLES = 10;
    localparam int          LIMIT      = 500000;
    localparam int          DRAIN      = 16;
    localparam logic [15:0] BODY_ALL   = 16'hFFFF;
    localparam logic [159:0] MF_PATH   = "META-INF/MANIFEST.MF";

    typedef enum logic [1:0] {
        NK_PATH = 2'd0,   // exact manifest path
        NK_NEAR = 2'd1,   // manifest path with one bit flipped
        NK_RAND = 2'd2
    } name_kind_e;

    typedef struct packed {
        t_verdict    verdict;
        logic [15:0] entries;
    } verdict_beat_t;

    typedef struct packed {
        logic [3:0]  plain;       // empty, streamed entries ahead of the header under test
        logic        with_hdr;
        logic [31:0] magic;
        logic [15:0] name_len;
        name_kind_e  nk;
        logic [15:0] extra;
        logic [31:0] packed_sz;
        logic [4:0]  hdr_keep;    // header bytes actually sent
        logic [15:0] body;        // bytes sent after the header, BODY_ALL for all
        logic [7:0]  tail;
        logic        typed;
        t_verdict    verdict;
        logic [15:0] entries;
    } archive_case_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_last;
    logic        o_valid;
    logic        i_ready;
    logic [1:0]  o_verdict;
    logic [15:0] o_entries_scanned;

    zip_local_header_manifest_scanner dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_data_byte       (i_data_byte),
        .i_last            (i_last),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_verdict         (o_verdict),
        .o_entries_scanned (o_entries_scanned)
    );

    // header walker state
    t_phase      walk_phase;
    logic [4:0]  hdr_idx;
    logic [31:0] hdr_magic;
    logic [15:0] hdr_nlen;
    logic [15:0] hdr_xlen;
    logic [31:0] hdr_psize;
    logic [4:0]  path_idx;
    logic        path_bad;
    logic [33:0] skip_left;
    logic [15:0] entries_seen;

    verdict_beat_t verdict_q[$];
    verdict_beat_t want;
    verdict_beat_t typed_beat;
    logic [7:0]    arch_q[$];
    bit            use_typed;

    int send_idle_pct;
    int recv_stall_pct;
    int errors;
    int live_bytes;
    int verdicts_issued;
    int archives_sent;
    int n_found, n_bad, n_none;

    archive_case_t dir_tab [17] = '{
        // single byte right after reset
        '{4'd0, 1'b0, 32'h0,        16'd0,     NK_RAND, 16'd0,     32'd0,        5'd0,
          BODY_ALL, 8'd1,  1'b1, VERDICT_NONE,  16'd0},
        '{4'd0, 1'b1, LOCAL_MAGIC,  PATH_LEN,  NK_PATH, 16'd0,     32'd0,        5'd30,
          BODY_ALL, 8'd0,  1'b1, VERDICT_FOUND, 16'd1},
        // bytes after the verdict are ignored
        '{4'd0, 1'b1, 32'h04034b51, 16'd0,     NK_RAND, 16'd0,     32'd0,        5'd30,
          BODY_ALL, 8'd4,  1'b1, VERDICT_BAD,   16'd0},
        '{4'd0, 1'b1, 32'hFFFFFFFF, 16'd0,     NK_RAND, 16'd0,     32'd0,        5'd30,
          BODY_ALL, 8'd0,  1'b1, VERDICT_BAD,   16'd0},
        '{4'd0, 1'b1, 32'h00000000, 16'd0,     NK_RAND, 16'd0,     32'd0,        5'd30,
          BODY_ALL, 8'd0,  1'b1, VERDICT_BAD,   16'd0},
        '{4'd0, 1'b1, 32'h504b0304, 16'd0,     NK_RAND, 16'd0,     32'd0,        5'd30,
          BODY_ALL, 8'd2,  1'b1, VERDICT_BAD,   16'd0},
        // zero-length entries chain straight into the next header
        '{4'd2, 1'b1, LOCAL_MAGIC,  PATH_LEN,  NK_PATH, 16'd3,     32'd5,        5'd30,
          BODY_ALL, 8'd6,  1'b1, VERDICT_FOUND, 16'd3},
        '{4'd3, 1'b1, 32'h04034b40, 16'd0,     NK_RAND, 16'd0,     32'd0,        5'd30,
          BODY_ALL, 8'd0,  1'b1, VERDICT_BAD,   16'd3},
        // bad magic, header one byte short: no magic verdict yet
        '{4'd0, 1'b1, 32'hDEADBEEF, 16'd0,     NK_RAND, 16'd0,     32'd0,        5'd29,
          16'd0,    8'd0,  1'b1, VERDICT_NONE,  16'd0},
        // name cut short by the end of data
        '{4'd0, 1'b1, LOCAL_MAGIC,  PATH_LEN,  NK_PATH, 16'd0,     32'd0,        5'd30,
          16'd7,    8'd0,  1'b1, VERDICT_NONE,  16'd1},
        '{4'd1, 1'b1, LOCAL_MAGIC,  PATH_LEN,  NK_PATH, 16'd0,     32'd0,        5'd12,
          16'd0,    8'd0,  1'b1, VERDICT_NONE,  16'd1},
        '{4'd0, 1'b1, LOCAL_MAGIC,  PATH_LEN,  NK_NEAR, 16'd2,     32'd3,        5'd30,
          BODY_ALL, 8'd0,  1'b1, VERDICT_NONE,  16'd1},
        '{4'd0, 1'b1, LOCAL_MAGIC,  PATH_LEN,  NK_NEAR, 16'd0,     32'd0,        5'd30,
          BODY_ALL, 8'd30, 1'b0, VERDICT_NONE,  16'd0},
        // widest sizes, archive ends mid-skip
        '{4'd0, 1'b1, LOCAL_MAGIC,  16'hFFFF,  NK_RAND, 16'hFFFF,  32'hFFFFFFFF, 5'd30,
          16'd40,   8'd0,  1'b1, VERDICT_NONE,  16'd1},
        '{4'd0, 1'b1, LOCAL_MAGIC,  PATH_LEN,  NK_NEAR, 16'hFFFF,  32'hFFFFFFFF, 5'd30,
          16'd25,   8'd0,  1'b1, VERDICT_NONE,  16'd1},
        '{4'd0, 1'b1, LOCAL_MAGIC,  16'd7,     NK_RAND, 16'd0,     32'h80000000, 5'd30,
          16'd10,   8'd0,  1'b0, VERDICT_NONE,  16'd0},
        // path bytes but wrong length: skipped, not compared
        '{4'd1, 1'b1, LOCAL_MAGIC,  16'd19,    NK_PATH, 16'd0,     32'd0,        5'd30,
          BODY_ALL, 8'd0,  1'b1, VERDICT_NONE,  16'd2}
    };

    function automatic logic [7:0] path_byte(input int idx);
        return MF_PATH[159 - 8*idx -: 8];
    endfunction

    function automatic void walk_reset();
        walk_phase   = PH_HEADER;
        hdr_idx      = '0;
        hdr_magic    = '0;
        hdr_nlen     = '0;
        hdr_xlen     = '0;
        hdr_psize    = '0;
        path_idx     = '0;
        path_bad     = 1'b0;
        skip_left    = '0;
        entries_seen = '0;
    endfunction

    function automatic void begin_skip(input logic [33:0] amount);
        skip_left  = amount;
        walk_phase = (amount != '0) ? PH_SKIP : PH_HEADER;
    endfunction

    // Advance the walker by one archive byte; hit is set when a verdict beat is due.
    function automatic void scan_byte(input logic [7:0] b, input bit is_last,
                                      output bit hit, output verdict_beat_t res);
        hit = 1'b0;
        res = '{VERDICT_NONE, 16'd0};
        case (walk_phase)
            PH_HEADER: begin
                if (hdr_idx == 0) begin
                    hdr_magic = '0;
                    hdr_psize = '0;
                    hdr_nlen  = '0;
                    hdr_xlen  = '0;
                end
                if (hdr_idx < MAGIC_END)
                    hdr_magic[8*hdr_idx +: 8] = b;
                else if (hdr_idx >= PSIZE_FIRST && hdr_idx < PSIZE_END)
                    hdr_psize[8*(hdr_idx - PSIZE_FIRST) +: 8] = b;
                else if (hdr_idx == NLEN_FIRST || hdr_idx == NLEN_FIRST + 1)
                    hdr_nlen[8*(hdr_idx - NLEN_FIRST) +: 8] = b;
                else if (hdr_idx == XLEN_FIRST || hdr_idx == XLEN_FIRST + 1)
                    hdr_xlen[8*(hdr_idx - XLEN_FIRST) +: 8] = b;
                if (hdr_idx == HDR_LAST) begin
                    hdr_idx = '0;
                    if (hdr_magic != LOCAL_MAGIC) begin
                        hit        = 1'b1;
                        res        = '{VERDICT_BAD, entries_seen};
                        walk_phase = PH_DONE;
                    end else begin
                        if (entries_seen != ENTRY_MAX)
                            entries_seen++;
                        if (hdr_nlen == PATH_LEN) begin
                            path_idx   = '0;
                            path_bad   = 1'b0;
                            walk_phase = PH_NAME;
                        end else begin
                            begin_skip(34'(hdr_nlen) + 34'(hdr_xlen) + 34'(hdr_psize));
                        end
                    end
                end else begin
                    hdr_idx++;
                end
            end
            PH_NAME: begin
                if (path_idx > PATH_LAST || b != path_byte(path_idx))
                    path_bad = 1'b1;
                if (path_idx == PATH_LAST) begin
                    path_idx = '0;
                    if (!path_bad) begin
                        hit        = 1'b1;
                        res        = '{VERDICT_FOUND, entries_seen};
                        walk_phase = PH_DONE;
                    end else begin
                        begin_skip(34'(hdr_xlen) + 34'(hdr_psize));
                    end
                end else begin
                    path_idx++;
                end
            end
            PH_SKIP: begin
                if (skip_left != '0)
                    skip_left--;
                if (skip_left == '0)
                    walk_phase = PH_HEADER;
            end
            default: ;
        endcase
        if (is_last) begin
            if (!hit && walk_phase != PH_DONE) begin
                hit = 1'b1;
                res = '{VERDICT_NONE, entries_seen};
            end
            walk_reset();
        end
    endfunction

    // Append one local header plus up to body_cap bytes of name/extra/data (negative: all).
    task automatic add_entry(input logic [31:0] magic, input logic [15:0] nlen,
                             input name_kind_e nk, input logic [15:0] xlen,
                             input logic [31:0] psize, input int hdr_keep,
                             input longint body_cap);
        logic [7:0] hdr_b [30];
        logic [7:0] c;
        longint     total;
        longint     cnt;
        int         near_pos;
        for (int i = 0; i < 30; i++)
            hdr_b[i] = 8'($urandom);
        for (int i = 0; i < 4; i++) begin
            hdr_b[i]      = magic[8*i +: 8];
            hdr_b[18 + i] = psize[8*i +: 8];
        end
        for (int i = 0; i < 2; i++) begin
            hdr_b[26 + i] = nlen[8*i +: 8];
            hdr_b[28 + i] = xlen[8*i +: 8];
        end
        for (int i = 0; i < hdr_keep; i++)
            arch_q.push_back(hdr_b[i]);
        if (hdr_keep == 30) begin
            total    = longint'(nlen) + longint'(xlen) + longint'(psize);
            cnt      = (body_cap < 0 || body_cap > total) ? total : body_cap;
            near_pos = $urandom_range(0, 19);
            for (longint i = 0; i < cnt; i++) begin
                if (i < nlen && i < 20 && nk != NK_RAND) begin
                    c = path_byte(int'(i));
                    if (nk == NK_NEAR && i == near_pos)
                        c = c ^ (8'h01 << $urandom_range(0, 7));
                end else begin
                    c = 8'($urandom);
                end
                arch_q.push_back(c);
            end
        end
    endtask

    task automatic add_random_entry();
        int         r;
        logic [15:0] nlen;
        name_kind_e  nk;
        r    = $urandom_range(0, 99);
        nlen = (r < 30) ? PATH_LEN : 16'($urandom_range(0, 12));
        nk   = (r < 20) ? NK_NEAR : NK_RAND;
        add_entry(LOCAL_MAGIC, nlen, nk,
                  ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(1, 5)),
                  ($urandom_range(0, 2) == 0) ? 32'd0 : 32'($urandom_range(1, 8)),
                  30, -1);
    endtask

    task automatic build_random_archive();
        int          r;
        int          keep;
        logic [31:0] magic;
        logic [15:0] nlen;
        arch_q.delete();
        r = $urandom_range(0, 99);
        if (r < 8) begin
            // plain noise
            repeat ($urandom_range(1, 60)) arch_q.push_back(8'($urandom));
        end else begin
            repeat ($urandom_range(0, 3)) add_random_entry();
            r = $urandom_range(0, 99);
            if (r < 35) begin
                add_entry(LOCAL_MAGIC, PATH_LEN, NK_PATH, 16'($urandom_range(0, 4)),
                          32'($urandom_range(0, 6)), 30, -1);
            end else if (r < 50) begin
                magic = ($urandom_range(0, 1) == 0) ?
                        (LOCAL_MAGIC ^ (32'h1 << $urandom_range(0, 31))) : $urandom;
                add_entry(magic, 16'($urandom_range(0, 12)), NK_RAND, 16'd0, 32'd0, 30, -1);
            end else if (r < 65) begin
                nlen = ($urandom_range(0, 3) == 0) ? 16'($urandom) : PATH_LEN;
                add_entry(LOCAL_MAGIC, nlen, (nlen == PATH_LEN) ? NK_NEAR : NK_RAND,
                          16'($urandom), $urandom, 30, $urandom_range(0, 40));
            end else if (r < 80) begin
                keep = $urandom_range(1, 30);
                add_entry(LOCAL_MAGIC, PATH_LEN, NK_PATH, 16'($urandom_range(0, 4)),
                          32'($urandom_range(0, 6)), keep,
                          (keep == 30) ? $urandom_range(0, 19) : 0);
            end
            repeat ($urandom_range(0, 6)) arch_q.push_back(8'($urandom));
        end
        if (arch_q.size() == 0)
            arch_q.push_back(8'($urandom));
    endtask

    task automatic build_case(input archive_case_t c);
        arch_q.delete();
        repeat (c.plain) add_entry(LOCAL_MAGIC, 16'd0, NK_RAND, 16'd0, 32'd0, 30, -1);
        if (c.with_hdr)
            add_entry(c.magic, c.name_len, c.nk, c.extra, c.packed_sz, int'(c.hdr_keep),
                      (c.body == BODY_ALL) ? -1 : longint'(c.body));
        repeat (c.tail) arch_q.push_back(8'($urandom));
        if (arch_q.size() == 0)
            arch_q.push_back(8'($urandom));
    endtask

    // Called at a rising edge; returns at the edge where the beat was taken.
    task automatic send_byte(input logic [7:0] b, input bit is_last);
        int            gap;
        bit            took;
        bit            hit;
        verdict_beat_t res;
        gap = 0;
        while ($urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last      <= is_last;
        took = 1'b0;
        while (!took) begin
            @(negedge i_clk);
            took = o_ready;
            @(posedge i_clk);
        end
        if (walk_phase != PH_DONE)
            live_bytes++;
        scan_byte(b, is_last, hit, res);
        if (hit) begin
            verdict_q.push_back(use_typed ? typed_beat : res);
            verdicts_issued++;
        end
    endtask

    task automatic send_archive();
        for (int k = 0; k < arch_q.size(); k++)
            send_byte(arch_q[k], k == arch_q.size() - 1);
        archives_sent++;
    endtask

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Output beats are stable from the negative edge up to the accepting edge.
    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            case (o_verdict)
                VERDICT_FOUND: n_found++;
                VERDICT_BAD:   n_bad++;
                default:       n_none++;
            endcase
            if (verdict_q.size() == 0) begin
                $display("%0t: unexpected verdict beat: verdict %0d entries %0d",
                         $time, o_verdict, o_entries_scanned);
                errors++;
            end else begin
                want = verdict_q.pop_front();
                if (o_verdict !== want.verdict) begin
                    $display("%0t: verdict mismatch: expected %0d, actual %0d",
                             $time, want.verdict, o_verdict);
                    errors++;
                end
                if (o_entries_scanned !== want.entries) begin
                    $display("%0t: entries_scanned mismatch: expected %0d, actual %0d",
                             $time, want.entries, o_entries_scanned);
                    errors++;
                end
            end
        end
    end

    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("%0t: timeout, %0d verdict beats still expected", $time, verdict_q.size());
        $display("[zip_local_header_manifest_scanner] ERROR");
        $finish;
    end

    initial begin
        int ph_bytes;
        int ph_verdicts;
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_data_byte     = 8'h00;
        i_last          = 1'b0;
        i_ready         = 1'b0;
        use_typed       = 1'b0;
        typed_beat      = '{VERDICT_NONE, 16'd0};
        errors          = 0;
        live_bytes      = 0;
        verdicts_issued = 0;
        archives_sent   = 0;
        n_found         = 0;
        n_bad           = 0;
        n_none          = 0;
        send_idle_pct   = 37;
        recv_stall_pct  = 80;
        walk_reset();
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < $size(dir_tab); r++) begin
            build_case(dir_tab[r]);
            use_typed  = dir_tab[r].typed;
            typed_beat = '{dir_tab[r].verdict, dir_tab[r].entries};
            send_archive();
            use_typed  = 1'b0;
        end

        // receiver-heavy stalling, then sender-heavy idling, then none
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct  = (ph == 0) ? 37 : (ph == 1) ? 80 : 0;
            recv_stall_pct = (ph == 0) ? 80 : (ph == 1) ? 37 : 0;
            ph_bytes       = live_bytes;
            ph_verdicts    = verdicts_issued;
            while (live_bytes - ph_bytes < 267 || verdicts_issued - ph_verdicts < 16) begin
                build_random_archive();
                send_archive();
            end
        end
        i_valid <= 1'b0;

        while (verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        $display("walked %0d archives, %0d live bytes; %0d verdict beats checked",
                 archives_sent, live_bytes, n_found + n_bad + n_none);
        $display("manifest found %0d, bad magic %0d, no manifest %0d",
                 n_found, n_bad, n_none);
        if (errors == 0)
            $display("[zip_local_header_manifest_scanner] OK");
        else
            $display("[zip_local_header_manifest_scanner] ERROR");
        $finish;
    end

endmodule
